### hdl/sm3_pkg.sv
`timescale 1ns / 1ps
// sm3_pkg: shared types, constants and round functions of the sm3 hash engine
// no dependencies

package sm3_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } q_word_t;

  typedef enum logic [2:0] {
    FR_ACCEPT, FR_MARK, FR_ZERO, FR_LEN_HI, FR_LEN_LO
  } front_state_t;

  typedef enum logic [1:0] {
    BK_COLLECT, BK_ROUND, BK_EMIT
  } back_state_t;

  localparam word_t SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam word_t T_LOW    = 32'h79CC4519;
  localparam word_t T_HIGH   = 32'h7A879D8A;
  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam logic [3:0] POS_LEN  = 4'd14;
  localparam logic [3:0] POS_LAST = 4'd15;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [5:0] ROUND_BOOL = 6'd16;
  localparam logic [2:0] FULL_COUNT = 3'd4;
  localparam logic [2:0] DIGEST_LAST = 3'd7;

  function automatic word_t rotl(word_t x, logic [4:0] k);
    logic [63:0] dbl;
    dbl = {x, x} >> (6'd32 - {1'b0, k});
    return dbl[31:0];
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  function automatic word_t t_const(logic [5:0] j);
    return rotl((j < ROUND_BOOL) ? T_LOW : T_HIGH, j[4:0]);
  endfunction

  function automatic word_t keep_mask(logic [1:0] n);
    word_t m;
    unique case (n)
      2'd0:    m = 32'h0000_0000;
      2'd1:    m = 32'hFF00_0000;
      2'd2:    m = 32'hFFFF_0000;
      default: m = 32'hFFFF_FF00;
    endcase
    return m;
  endfunction

endpackage

### hdl/sm3_if.sv
`timescale 1ns / 1ps
// sm3_in_if, sm3_out_if: valid/ready channels of the sm3 hash engine
// no dependencies

interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;
  modport source(output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink(input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source(output valid, digest_word, digest_last, input ready);
  modport sink(input valid, digest_word, digest_last, output ready);
endinterface

### hdl/sm3_front.sv
`timescale 1ns / 1ps
// sm3_front: takes message items, tracks length and inserts the padding words
// depends on sm3_pkg and sm3_in_if

module sm3_front import sm3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sm3_in_if.sink    in_ch,
  output q_word_t   push_data,
  output logic      push_valid,
  input  logic      push_ready
);

  front_state_t state_r, state_nxt;
  logic [3:0]   pos_r, pos_nxt, pos_inc;
  logic [63:0]  len_r, len_nxt;
  logic [2:0]   cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_ACCEPT;
      pos_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
    end
  end

  always_comb begin
    cnt = (!in_ch.end_of_message || in_ch.valid_bytes > FULL_COUNT) ? FULL_COUNT
        : in_ch.valid_bytes;
    pos_inc    = pos_r + 4'd1;
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    push_valid = 1'b0;
    push_data  = '0;
    in_ch.ready = (state_r == FR_ACCEPT) && push_ready;
    unique case (state_r)
      FR_ACCEPT: begin
        push_valid = in_ch.valid;
        if (cnt == FULL_COUNT) begin
          push_data.word = in_ch.message_word;
        end else begin
          push_data.word = (in_ch.message_word & keep_mask(cnt[1:0]))
                         | (PAD_WORD >> {cnt[1:0], 3'b000});
        end
        if (in_ch.valid && push_ready) begin
          pos_nxt = pos_inc;
          len_nxt = len_r + {58'd0, cnt, 3'b000};
          if (in_ch.end_of_message) begin
            if (cnt == FULL_COUNT) begin
              state_nxt = FR_MARK;
            end else begin
              state_nxt = (pos_inc == POS_LEN) ? FR_LEN_HI : FR_ZERO;
            end
          end
        end
      end
      FR_MARK, FR_ZERO: begin
        push_valid     = 1'b1;
        push_data.word = (state_r == FR_MARK) ? PAD_WORD : '0;
        if (push_ready) begin
          pos_nxt   = pos_inc;
          state_nxt = (pos_inc == POS_LEN) ? FR_LEN_HI : FR_ZERO;
        end
      end
      FR_LEN_HI: begin
        push_valid     = 1'b1;
        push_data.word = len_r[63:32];
        if (push_ready) begin
          pos_nxt   = pos_inc;
          state_nxt = FR_LEN_LO;
        end
      end
      FR_LEN_LO: begin
        push_valid     = 1'b1;
        push_data.word = len_r[31:0];
        push_data.fin  = 1'b1;
        if (push_ready) begin
          pos_nxt   = '0;
          len_nxt   = '0;
          state_nxt = FR_ACCEPT;
        end
      end
      default: state_nxt = FR_ACCEPT;
    endcase
  end

endmodule

### hdl/sm3_queue.sv
`timescale 1ns / 1ps
// sm3_queue: small word queue between the front and the compression core
// depends on sm3_pkg

module sm3_queue import sm3_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_word_t push_data,
  input  logic    push_valid,
  output logic    push_ready,
  output q_word_t pop_data,
  output logic    pop_valid,
  input  logic    pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_word_t        mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

### hdl/sm3_core.sv
`timescale 1ns / 1ps
// sm3_core: gathers 16-word blocks, runs the 64 rounds and sends the digest
// depends on sm3_pkg and sm3_out_if

module sm3_core import sm3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_word_t   pop_data,
  input  logic      pop_valid,
  output logic      pop_ready,
  sm3_out_if.source out_ch
);

  back_state_t st_r, st_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [5:0]  j_r, j_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  word_t       v_r [8];
  word_t       v_nxt [8];
  word_t       r_r [8];
  word_t       r_nxt [8];
  word_t       w_r [16];
  word_t       w_nxt [16];
  word_t       a12, ss1, ss2, ff, gg, tt1, tt2, new_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_COLLECT;
      cnt_r <= '0;
      j_r   <= '0;
      idx_r <= '0;
      fin_r <= 1'b0;
      v_r   <= SM3_IV;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      j_r   <= j_nxt;
      idx_r <= idx_nxt;
      fin_r <= fin_nxt;
      v_r   <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    w_r <= w_nxt;
  end

  always_comb begin
    a12   = rotl(r_r[0], 5'd12);
    ss1   = rotl(a12 + r_r[4] + t_const(j_r), 5'd7);
    ss2   = ss1 ^ a12;
    if (j_r < ROUND_BOOL) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1   = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2   = gg + r_r[7] + ss1 + w_r[0];
    new_w = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15))
          ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    j_nxt   = j_r;
    idx_nxt = idx_r;
    fin_nxt = fin_r;
    v_nxt   = v_r;
    r_nxt   = r_r;
    w_nxt   = w_r;
    pop_ready          = (st_r == BK_COLLECT);
    out_ch.valid       = (st_r == BK_EMIT);
    out_ch.digest_word = v_r[idx_r];
    out_ch.digest_last = (idx_r == DIGEST_LAST);
    unique case (st_r)
      BK_COLLECT: begin
        if (pop_valid) begin
          for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
          w_nxt[15] = pop_data.word;
          cnt_nxt   = cnt_r + 4'd1;
          if (cnt_r == POS_LAST) begin
            fin_nxt = pop_data.fin;
            r_nxt   = v_r;
            j_nxt   = '0;
            st_nxt  = BK_ROUND;
          end
        end
      end
      BK_ROUND: begin
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = new_w;
        r_nxt[0] = tt1;
        r_nxt[1] = r_r[0];
        r_nxt[2] = rotl(r_r[1], 5'd9);
        r_nxt[3] = r_r[2];
        r_nxt[4] = perm0(tt2);
        r_nxt[5] = r_r[4];
        r_nxt[6] = rotl(r_r[5], 5'd19);
        r_nxt[7] = r_r[6];
        j_nxt    = j_r + 6'd1;
        if (j_r == ROUND_LAST) begin
          for (int i = 0; i < 8; i++) v_nxt[i] = v_r[i] ^ r_nxt[i];
          idx_nxt = '0;
          st_nxt  = fin_r ? BK_EMIT : BK_COLLECT;
        end
      end
      BK_EMIT: begin
        if (out_ch.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == DIGEST_LAST) begin
            v_nxt  = SM3_IV;
            st_nxt = BK_COLLECT;
          end
        end
      end
      default: st_nxt = BK_COLLECT;
    endcase
  end

endmodule

### hdl/sm3_hash_engine.sv
`timescale 1ns / 1ps
// sm3_hash_engine: streaming sm3 hash, 32-bit message items in, eight digest items out
// one compression round per cycle: a 16-word block is collected word by word, then
// runs its rounds; the core takes no new words during rounds, so the queue holds them until full
// padding adds 2 to 18 words after the final item, then the eight digest words go out
// the first digest word follows the rounds of the final block, and may wait behind a busy block
// synchronous active-low reset returns the chaining value to the iv and empties the queue

module sm3_hash_engine import sm3_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  q_word_t push_data, pop_data;
  logic    push_valid, push_ready, pop_valid, pop_ready;

  sm3_front u_front (
    .clk, .rst_n, .in_ch,
    .push_data, .push_valid, .push_ready
  );

  sm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push_data, .push_valid, .push_ready,
    .pop_data, .pop_valid, .pop_ready
  );

  sm3_core u_core (
    .clk, .rst_n,
    .pop_data, .pop_valid, .pop_ready, .out_ch
  );

`ifndef SYNTH
  a_pad_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.end_of_message |=> !in_ch.ready)
    else $error("item taken while padding pending");

  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.digest_last |=> !out_ch.valid)
    else $error("digest runs past its last word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !pop_ready)
    else $error("queue drained while digest pending");
`endif

endmodule
